// ===== rtl/core/swdg_pkg.sv =====
package swdg_pkg;

  // Field widths.
  localparam int IDX_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int MASK_W  = 4;
  localparam int PW_W    = 16;
  localparam int MM_W    = 8;   // mask side squared, at most 225
  localparam int PP_W    = 9;   // descriptors per pixel, at most 451
  localparam int REM_W   = PP_W;
  localparam int ROW_W   = MASK_W;
  localparam int ROWOFF_W = ROW_W + PW_W;
  localparam int BYTES_W = 3;

  localparam int MAX_MASK    = 15;
  localparam int DESC_STRIDE = 64;
  localparam int XFER_BYTES  = 4;

  // The pixel/slot divide retires this many quotient bits per stage.
  localparam int DIV_BITS_PER_STAGE = 8;
  localparam int DIV_STAGES = IDX_W / DIV_BITS_PER_STAGE;
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  localparam int OUT_FIELDS_W = 4 * ADDR_W + BYTES_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [2:0] {
    REG_MASK_SIZE       = 3'd0,
    REG_PICTURE_WIDTH   = 3'd1,
    REG_DESCRIPTOR_BASE = 3'd2,
    REG_LEFT_BASE       = 3'd3,
    REG_RIGHT_BASE      = 3'd4,
    REG_DEST_BASE       = 3'd5,
    REG_UNIT_BASE       = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    SLOT_LEFT   = 2'd0,
    SLOT_RIGHT  = 2'd1,
    SLOT_RESULT = 2'd2
  } slot_kind_t;

  typedef struct packed {
    logic [MASK_W-1:0] m;
    logic [MM_W-1:0]   mm;
    logic [PP_W-1:0]   per_pixel;
    logic [PW_W-1:0]   picture_width;
    logic [ADDR_W-1:0] descriptor_base;
    logic [ADDR_W-1:0] left_base;
    logic [ADDR_W-1:0] right_base;
    logic [ADDR_W-1:0] dest_base;
    logic [ADDR_W-1:0] unit_base;
  } cfg_t;

  typedef struct packed {
    logic                last;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    quo;       // dividend, shifts into the pixel number
    logic [REM_W-1:0]    rem;       // partial remainder, ends as the slot number
    slot_kind_t          kind;
    logic [MM_W-1:0]     win;       // position inside the window
    logic [ROW_W-1:0]    row;
    logic [MASK_W-1:0]   col;
    logic [ROWOFF_W-1:0] row_off;
    logic [ADDR_W-1:0]   desc_addr;
  } item_t;

  // Restoring division of the index by the per-pixel count, one slice.
  function automatic item_t div_slice(item_t it, logic [PP_W-1:0] divisor);
    item_t o;
    logic [REM_W:0] r;
    o = it;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      r = {o.rem, o.quo[IDX_W-1]};
      o.quo = {o.quo[IDX_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
        o.quo[0] = 1'b1;
      end
      o.rem = r[REM_W-1:0];
    end
    return o;
  endfunction

  // Decides left window, right window or result copy, and forms the
  // descriptor's own address.
  function automatic item_t classify(item_t it, cfg_t cfg);
    item_t o;
    o = it;
    o.desc_addr = cfg.descriptor_base + (it.idx * ADDR_W'(DESC_STRIDE));
    if (it.rem < {1'b0, cfg.mm}) begin
      o.kind = SLOT_LEFT;
      o.win  = it.rem[MM_W-1:0];
    end else if (it.rem < {cfg.mm, 1'b0}) begin
      o.kind = SLOT_RIGHT;
      o.win  = MM_W'(it.rem - {1'b0, cfg.mm});
    end else begin
      o.kind = SLOT_RESULT;
      o.win  = '0;
    end
    return o;
  endfunction

  // Splits the window position into row and column. The position is below
  // m*m, so the row fits in four quotient bits.
  function automatic item_t window_split(item_t it, logic [MASK_W-1:0] m);
    item_t o;
    logic [MM_W-1:0] r;
    logic [MM_W-1:0] d;
    o = it;
    r = it.win;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      d = MM_W'(m) << i;
      o.row[i] = (r >= d);
      if (r >= d) begin
        r = r - d;
      end
    end
    o.col = r[MASK_W-1:0];
    return o;
  endfunction

  function automatic item_t row_offset(item_t it, logic [PW_W-1:0] pw);
    item_t o;
    o = it;
    o.row_off = ROWOFF_W'(it.row) * ROWOFF_W'(pw);
    return o;
  endfunction

endpackage

// ===== rtl/core/stereo_window_dma_descriptor_gen_unit.sv =====
// Throughput: one descriptor per cycle while the output is not stalled; the
// 32-bit index divide retires eight quotient bits in each of four pipeline
// stages, followed by three stages of window decode and one output register.
// Reset clears all valid bits and loads the configuration registers with
// their reset values.
module stereo_window_dma_descriptor_gen_unit
  import swdg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IDX_W-1:0]      s_tdata,  // [31:0] desc_index
  input  logic                  s_tlast,  // is_last
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] descriptor_address, [63:32] next_descriptor_address,
  // [95:64] source_address, [127:96] destination_address,
  // [130:128] transfer_bytes, [135:131] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  cfg_t cfg;

  logic [MASK_W-1:0] wr_m;
  logic [MM_W-1:0]   wr_mm;

  // The window side saturates at the largest supported mask. Its square and
  // the per-pixel descriptor count are kept in registers so the divider sees
  // a settled divisor.
  always_comb begin
    wr_m = (cfg_data[MASK_W-1:0] > MASK_W'(MAX_MASK)) ? MASK_W'(MAX_MASK)
                                                      : cfg_data[MASK_W-1:0];
    wr_mm = MM_W'(wr_m) * MM_W'(wr_m);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.m               <= MASK_W'(3);
      cfg.mm              <= MM_W'(9);
      cfg.per_pixel       <= PP_W'(19);
      cfg.picture_width   <= PW_W'(16);
      cfg.descriptor_base <= '0;
      cfg.left_base       <= '0;
      cfg.right_base      <= '0;
      cfg.dest_base       <= '0;
      cfg.unit_base       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_MASK_SIZE: begin
          cfg.m         <= wr_m;
          cfg.mm        <= wr_mm;
          cfg.per_pixel <= {wr_mm, 1'b1};
        end
        REG_PICTURE_WIDTH:   cfg.picture_width   <= cfg_data[PW_W-1:0];
        REG_DESCRIPTOR_BASE: cfg.descriptor_base <= cfg_data;
        REG_LEFT_BASE:       cfg.left_base       <= cfg_data;
        REG_RIGHT_BASE:      cfg.right_base      <= cfg_data;
        REG_DEST_BASE:       cfg.dest_base       <= cfg_data;
        REG_UNIT_BASE:       cfg.unit_base       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each accepted transaction starts with an empty remainder; the index
  // itself is the dividend.
  item_t in_item;
  always_comb begin
    in_item      = '0;
    in_item.last = s_tlast;
    in_item.idx  = s_tdata;
    in_item.quo  = s_tdata;
  end

  logic  pipe_valid;
  logic  pipe_ready;
  item_t pipe_item;

  swdg_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_item  (pipe_item)
  );

  // Final address sums. Left slots add the pixel number to the window
  // position; right slots do not. The result slot copies the unit's output
  // word to the pixel's place in the result buffer.
  logic [ADDR_W-1:0] pixel;
  logic [ADDR_W-1:0] slot_dst;
  logic [ADDR_W-1:0] win_off;
  logic [ADDR_W-1:0] src_nxt;
  logic [ADDR_W-1:0] dst_nxt;
  logic [ADDR_W-1:0] next_nxt;

  always_comb begin
    pixel    = pipe_item.quo;
    slot_dst = cfg.unit_base + ADDR_W'(pipe_item.rem);
    win_off  = ADDR_W'(pipe_item.col) + ADDR_W'(pipe_item.row_off);
    case (pipe_item.kind)
      SLOT_LEFT: begin
        src_nxt = cfg.left_base + win_off + pixel;
        dst_nxt = slot_dst;
      end
      SLOT_RIGHT: begin
        src_nxt = cfg.right_base + win_off;
        dst_nxt = slot_dst;
      end
      default: begin
        src_nxt = cfg.unit_base;
        dst_nxt = cfg.dest_base + pixel;
      end
    endcase
    next_nxt = pipe_item.last ? cfg.descriptor_base
                              : pipe_item.desc_addr + ADDR_W'(DESC_STRIDE);
  end

  // Output register: it takes a new result whenever it is empty or its
  // current transaction completes, so the pipeline keeps moving under it.
  logic [ADDR_W-1:0] desc_q;
  logic [ADDR_W-1:0] next_q;
  logic [ADDR_W-1:0] src_q;
  logic [ADDR_W-1:0] dst_q;

  assign pipe_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pipe_ready) begin
      m_tvalid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready && pipe_valid) begin
      desc_q <= pipe_item.desc_addr;
      next_q <= next_nxt;
      src_q  <= src_nxt;
      dst_q  <= dst_nxt;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, BYTES_W'(XFER_BYTES), dst_q, src_q, next_q, desc_q};

  // The input side only stalls when every stage is full behind a stalled
  // output.
  a_stall_only_on_backpressure: assert property (
    @(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready)
  ) else $error("input stalled without output backpressure");

  // The per-pixel count always matches the stored window square.
  a_per_pixel_consistent: assert property (
    @(posedge clk) disable iff (rst)
    cfg.per_pixel == {cfg.mm, 1'b1}
  ) else $error("per-pixel count out of step with mask size");

  // The next pointer either wraps to the base or follows by one stride.
  a_next_pointer: assert property (
    @(posedge clk) disable iff (rst)
    m_tvalid |-> ((next_q == cfg.descriptor_base) ||
                  (next_q == desc_q + ADDR_W'(DESC_STRIDE)))
  ) else $error("next descriptor address inconsistent");

  // The slot number leaving the pipeline is always below the per-pixel count.
  a_slot_in_range: assert property (
    @(posedge clk) disable iff (rst)
    pipe_valid |-> (pipe_item.rem < cfg.per_pixel)
  ) else $error("slot number not below the per-pixel count");

endmodule

// ===== rtl/core/swdg_pipe.sv =====
module swdg_pipe
  import swdg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t stage_src [PIPE_STAGES];
  item_t stage_nxt [PIPE_STAGES];
  item_t stage_q   [PIPE_STAGES];
  logic  src_vld   [PIPE_STAGES];
  logic  vld       [PIPE_STAGES];
  logic  rdy       [PIPE_STAGES+1];

  assign rdy[PIPE_STAGES] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld[PIPE_STAGES-1];
  assign out_item  = stage_q[PIPE_STAGES-1];

  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stage
    logic  v;
    item_t d;

    if (k == 0) begin : g_first
      assign stage_src[k] = in_item;
      assign src_vld[k]   = in_valid;
    end else begin : g_rest
      assign stage_src[k] = stage_q[k-1];
      assign src_vld[k]   = vld[k-1];
    end

    if (k < DIV_STAGES) begin : g_div
      assign stage_nxt[k] = div_slice(stage_src[k], cfg.per_pixel);
    end else if (k == DIV_STAGES) begin : g_cls
      assign stage_nxt[k] = classify(stage_src[k], cfg);
    end else if (k == DIV_STAGES + 1) begin : g_win
      assign stage_nxt[k] = window_split(stage_src[k], cfg.m);
    end else begin : g_mul
      assign stage_nxt[k] = row_offset(stage_src[k], cfg.picture_width);
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy[k]     = !v || rdy[k+1];
    assign vld[k]     = v;
    assign stage_q[k] = d;

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (rdy[k]) begin
        v <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld[k]) begin
        d <= stage_nxt[k];
      end
    end
  end

endmodule

// ===== tb/sv/stereo_window_dma_descriptor_gen_unit_test.sv =====
// Self-checking testbench for the stereo window-matching DMA descriptor generator.
//
// A descriptor index and its chain-end flag go in on the slave stream. The
// testbench keeps its own copy of the seven configuration registers and
// computes each descriptor in place: the descriptor address, the next
// pointer, the source and destination of the transfer, and the byte count.
// Every accepted request pushes its descriptor onto a FIFO. A separate
// process pops that FIFO on each master-side transaction and compares the
// result field by field.
//
// The run goes through these steps in order:
//   - directed requests at the reset configuration,
//   - the largest window with every base at the top of the address space,
//     so that all address sums wrap,
//   - a one-by-one window and a zero window,
//   - a long receiver hold-off while the sender keeps pushing,
//   - random phases with fresh configurations,
//   - a tail with no idling on either side.
// Configuration writes happen only once the pipeline has drained.
module stereo_window_dma_descriptor_gen_unit_test;
  import swdg_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;  // idle wait after the last result, plus margin
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 160;

  typedef struct packed {
    logic [ADDR_W-1:0]  self_addr;
    logic [ADDR_W-1:0]  next_addr;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [BYTES_W-1:0] bytes;
  } descriptor_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IDX_W-1:0]      s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = REG_MASK_SIZE;
  logic [ADDR_W-1:0]     cfg_data = '0;

  // Our copy of the configuration registers, updated on each accepted write.
  logic [MASK_W-1:0] win_side   = 4'd3;
  logic [PW_W-1:0]   row_stride = 16'd16;
  logic [ADDR_W-1:0] chain_base = '0;
  logic [ADDR_W-1:0] left_pic   = '0;
  logic [ADDR_W-1:0] right_pic  = '0;
  logic [ADDR_W-1:0] result_buf = '0;
  logic [ADDR_W-1:0] unit_slots = '0;

  descriptor_t pending_descriptors[$];

  int  failures = 0;
  int  requests_sent = 0;
  int  descriptors_checked = 0;
  int  setups_written = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  int  rx_gap = 0;
  bit  idling = 1'b1;

  stereo_window_dma_descriptor_gen_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d descriptors still pending",
               cycle_count, pending_descriptors.size());
      $display("stereo_window_dma_descriptor_gen_unit verification failed");
      $finish;
    end
  end

  // Computes the descriptor that one index produces under the current
  // configuration. The index splits into a pixel number and a slot within
  // that pixel's group of 2*M*M+1 descriptors. Left slots add the pixel
  // offset. Right slots do not. The final slot copies the unit's result out.
  function automatic descriptor_t predict_descriptor(logic [IDX_W-1:0] idx, logic last);
    descriptor_t d;
    logic [31:0] side, area, per_pixel, pixel, slot, pos;
    side = 32'(win_side);
    if (side > MAX_MASK) side = MAX_MASK;
    area      = side * side;
    per_pixel = 32'd2 * area + 32'd1;
    pixel     = idx / per_pixel;
    slot      = idx % per_pixel;
    d.self_addr = chain_base + idx * 32'(DESC_STRIDE);
    d.next_addr = last ? chain_base : chain_base + (idx + 32'd1) * 32'(DESC_STRIDE);
    if (slot < area) begin
      d.src_addr = left_pic + slot % side + (slot / side) * 32'(row_stride) + pixel;
      d.dst_addr = unit_slots + slot;
    end else if (slot < 32'd2 * area) begin
      pos        = slot - area;
      d.src_addr = right_pic + pos % side + (pos / side) * 32'(row_stride);
      d.dst_addr = unit_slots + slot;
    end else begin
      // With a zero window every index lands here, one descriptor per pixel.
      d.src_addr = unit_slots;
      d.dst_addr = result_buf + pixel;
    end
    d.bytes = BYTES_W'(XFER_BYTES);
    return d;
  endfunction

  task automatic note_failure(string msg);
    if (failures < 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    failures++;
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      note_failure($sformatf("%s expected %h actual %h", field, want, got));
    end
  endtask

  // Result checker: each master-side transaction is matched against the
  // oldest pending descriptor.
  always @(posedge clk) begin : check_results
    descriptor_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      descriptors_checked++;
      if (pending_descriptors.size() == 0) begin
        note_failure($sformatf("descriptor %h arrived with none pending", m_tdata));
      end else begin
        want = pending_descriptors.pop_front();
        compare_field("descriptor_address", want.self_addr, m_tdata[31:0]);
        compare_field("next_descriptor_address", want.next_addr, m_tdata[63:32]);
        compare_field("source_address", want.src_addr, m_tdata[95:64]);
        compare_field("destination_address", want.dst_addr, m_tdata[127:96]);
        compare_field("transfer_bytes", 32'(want.bytes), 32'(m_tdata[130:128]));
        compare_field("padding", 32'd0, 32'(m_tdata[OUT_DATA_W-1:OUT_FIELDS_W]));
      end
    end
  end

  // Receiver. A requested hold-off is counted down here first. Otherwise
  // tready drops for random stretches while idling is on.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap   <= rx_gap - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      rx_gap   <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offers one request and waits for its transaction. A random gap may come
  // first. tvalid stays high between back-to-back requests.
  task automatic send_request(logic [IDX_W-1:0] idx, logic last);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= idx;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_descriptors.push_back(predict_descriptor(idx, last));
    requests_sent++;
  endtask

  // Stops offering requests and waits until every pending descriptor has
  // come back. It then waits out the pipeline before any register write.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_descriptors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_MASK_SIZE:       win_side   = value[MASK_W-1:0];
      REG_PICTURE_WIDTH:   row_stride = value[PW_W-1:0];
      REG_DESCRIPTOR_BASE: chain_base = value;
      REG_LEFT_BASE:       left_pic   = value;
      REG_RIGHT_BASE:      right_pic  = value;
      REG_DEST_BASE:       result_buf = value;
      REG_UNIT_BASE:       unit_slots = value;
      default: ;
    endcase
  endtask

  // Writes all seven registers. Random junk goes into the unused upper bits
  // of the narrow registers, and the block must ignore it.
  task automatic configure(logic [MASK_W-1:0] side, logic [PW_W-1:0] stride,
                           logic [ADDR_W-1:0] cbase, logic [ADDR_W-1:0] lbase,
                           logic [ADDR_W-1:0] rbase, logic [ADDR_W-1:0] dbase,
                           logic [ADDR_W-1:0] ubase);
    write_reg(REG_MASK_SIZE, ($urandom() & 32'hFFFF_FFF0) | 32'(side));
    write_reg(REG_PICTURE_WIDTH, ($urandom() & 32'hFFFF_0000) | 32'(stride));
    write_reg(REG_DESCRIPTOR_BASE, cbase);
    write_reg(REG_LEFT_BASE, lbase);
    write_reg(REG_RIGHT_BASE, rbase);
    write_reg(REG_DEST_BASE, dbase);
    write_reg(REG_UNIT_BASE, ubase);
    cfg_valid <= 1'b0;
    @(posedge clk);
    setups_written++;
  endtask

  task automatic configure_random;
    configure(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // Number of descriptors in one pixel's group under the current window.
  function automatic logic [31:0] group_size();
    logic [31:0] side;
    side = 32'(win_side);
    return 32'd2 * side * side + 32'd1;
  endfunction

  // Sends one chain the way the driver builds it: consecutive indices from
  // the start of a pixel's group, with the last flag on the final one.
  task automatic send_chain(int len);
    logic [31:0] first;
    logic [31:0] pick;
    pick  = $urandom();
    first = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 2000)) * group_size()
                                        : pick - pick % group_size();
    for (int i = 0; i < len; i++) begin
      send_request(first + 32'(i), i == len - 1);
    end
  endtask

  // Picks an index near the edges of the left, right and result slots, or
  // anywhere at all.
  task automatic send_scattered;
    logic [31:0] side, area, base, pick;
    side = 32'(win_side);
    area = side * side;
    pick = $urandom();
    base = pick - pick % group_size();
    case ($urandom_range(0, 5))
      0: send_request(base, 1'($urandom()));
      1: send_request(base + area - 32'd1, 1'($urandom()));
      2: send_request(base + area, 1'($urandom()));
      3: send_request(base + 32'd2 * area - 32'd1, 1'($urandom()));
      4: send_request(base + 32'd2 * area, 1'($urandom()));
      default: send_request($urandom(), 1'($urandom()));
    endcase
  endtask

  // At the reset configuration (3x3 window, width 16, zero bases) a pixel's
  // group is 19 descriptors: slots 0..8 are left, 9..17 right and 18 the result.
  task automatic test_reset_values;
    send_request(32'd0, 1'b0);
    send_request(32'd8, 1'b0);
    send_request(32'd9, 1'b0);
    send_request(32'd17, 1'b0);
    send_request(32'd18, 1'b1);
    send_request(32'd19, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    send_request(32'hFFFF_FFFE, 1'b0);
    drain();
  endtask

  // Largest window and widest picture with every base at the top of the
  // address space, so each sum wraps. Group size is 451.
  task automatic test_extreme_window;
    configure(4'd15, 16'hFFFF, '1, '1, '1, '1, '1);
    send_request(32'd0, 1'b0);
    send_request(32'd224, 1'b0);
    send_request(32'd225, 1'b0);
    send_request(32'd449, 1'b0);
    send_request(32'd450, 1'b1);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  // A one-by-one window with a zero picture width. Then a zero window, where
  // every index is a result copy and the pixel number equals the index.
  task automatic test_small_windows;
    configure(4'd1, 16'd0, 32'h0000_1000, 32'h2000_0000, 32'h3000_0000,
              32'h4000_0000, 32'h5000_0000);
    send_request(32'd0, 1'b0);
    send_request(32'd1, 1'b0);
    send_request(32'd2, 1'b1);
    send_request(32'd3, 1'b0);
    drain();
    configure(4'd0, 16'd1, '0, '0, '0, 32'hFFFF_FFF0, 32'h8000_0000);
    send_request(32'd0, 1'b0);
    send_request(32'd5, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b0);
    drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps pushing,
  // so the pipeline fills up and s_tready has to drop.
  task automatic test_backpressure;
    configure_random();
    idling = 1'b0;
    hold_left <= HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_scattered();
    drain();
    idling = 1'b1;
  endtask

  // Random phases. The first three use the extreme settings and the rest are
  // random. Most traffic is well-formed chains and the rest scattered indices.
  // Some phases run with no idling at all.
  task automatic test_random_phases;
    int sent;
    int len;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(4'd15, 16'd0, '1, '0, '1, '0, '1);
        1: configure(4'd0, 16'hFFFF, $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
        2: configure(4'd1, 16'hFFFF, '0, '1, '0, '1, '0);
        default: configure_random();
      endcase
      idling = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 6) begin
          len = $urandom_range(1, 40);
          send_chain(len);
          sent += len;
        end else begin
          send_scattered();
          sent++;
        end
      end
      drain();
    end
    idling = 1'b1;
  endtask

  // Final stretch with both sides always ready.
  task automatic test_quiet_tail;
    configure_random();
    idling = 1'b0;
    send_chain(20);
    for (int i = 0; i < 10; i++) send_scattered();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_extreme_window();
    test_small_windows();
    test_backpressure();
    test_random_phases();
    test_quiet_tail();

    if (pending_descriptors.size() != 0) begin
      note_failure($sformatf("%0d descriptors never arrived", pending_descriptors.size()));
    end
    $display("Sent %0d descriptor requests under %0d register setups (window sides 0, 1, 15",
             requests_sent, setups_written);
    $display("and random), checked %0d descriptors, %0d mismatches.",
             descriptors_checked, failures);
    if (failures == 0) begin
      $display("stereo_window_dma_descriptor_gen_unit verification clean");
    end else begin
      $display("stereo_window_dma_descriptor_gen_unit verification failed");
    end
    $finish;
  end

endmodule
